// ----- src/isrr_pkg.sv -----
`timescale 1ns / 1ps

package isrr_pkg;

    // Default width of the radicand word.
    localparam int DEFAULT_RADICAND_WIDTH = 32;

    // Rounding mode held in the configuration register.
    typedef enum logic [0:0] {
        ROUND_FLOOR   = 1'b0,
        ROUND_NEAREST = 1'b1
    } round_mode_t;

endpackage

// ----- src/isrr_cell.sv -----
`timescale 1ns / 1ps

// One step of the restoring binary square root walk. The cell makes one trial
// subtraction of (acc + bit) from the partial remainder, where bit is a fixed
// power of four that belongs to this position in the chain, and hands the
// updated remainder and scaled root to the next cell.
module isrr_cell #(
    parameter int WALK_WIDTH = 32,
    parameter int STAGE      = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WALK_WIDTH-1:0] in_part,
    input  logic [WALK_WIDTH-1:0] in_acc,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WALK_WIDTH-1:0] out_part,
    output logic [WALK_WIDTH-1:0] out_acc
);

    localparam int BIT_POS = WALK_WIDTH - 2 - 2 * STAGE;
    localparam logic [WALK_WIDTH:0] BIT = (WALK_WIDTH + 1)'(1) << BIT_POS;

    logic                  valid_reg;
    logic [WALK_WIDTH-1:0] part_reg;
    logic [WALK_WIDTH-1:0] acc_reg;
    logic [WALK_WIDTH-1:0] part_next;
    logic [WALK_WIDTH-1:0] acc_next;
    logic [WALK_WIDTH:0]   trial;
    logic [WALK_WIDTH:0]   acc_wide;
    logic                  take;

    // The cell takes a new word when empty or when its word moves on.
    assign in_ready = !valid_reg || out_ready;

    // Trial subtraction and the halving of the scaled root.
    always_comb begin
        trial = {1'b0, in_acc} + BIT;
        take  = ({1'b0, in_part} >= trial);
        if (take) begin
            part_next = in_part - trial[WALK_WIDTH-1:0];
            acc_wide  = trial + BIT;
        end else begin
            part_next = in_part;
            acc_wide  = {1'b0, in_acc};
        end
        acc_next = acc_wide[WALK_WIDTH:1];
    end

    // Valid flag of the stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload of the stage.
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            part_reg <= part_next;
            acc_reg  <= acc_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_part  = part_reg;
    assign out_acc   = acc_reg;

endmodule

// ----- src/isrr_round.sv -----
`timescale 1ns / 1ps

// Output stage: applies the rounding step to the floor root and holds the
// finished word until the receiver takes it.
module isrr_round #(
    parameter int HALF_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  isrr_pkg::round_mode_t       round_mode,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2*HALF_WIDTH-1:0]     in_part,
    input  logic [2*HALF_WIDTH-1:0]     in_acc,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [HALF_WIDTH:0]         m_root,
    output logic [HALF_WIDTH:0]         m_remainder,
    output logic                        m_rounded_up
);

    logic                valid_reg;
    logic [HALF_WIDTH:0] root_reg;
    logic [HALF_WIDTH:0] rem_reg;
    logic                up_reg;
    logic [HALF_WIDTH:0] floor_root;
    logic [HALF_WIDTH:0] rem;
    logic [HALF_WIDTH:0] root_next;
    logic                up_next;

    assign in_ready = !valid_reg || m_ready;

    // Round to nearest when the floor remainder exceeds the floor root.
    always_comb begin
        floor_root = {1'b0, in_acc[HALF_WIDTH-1:0]};
        rem        = in_part[HALF_WIDTH:0];
        up_next    = (round_mode == isrr_pkg::ROUND_NEAREST) && (rem > floor_root);
        root_next  = floor_root + {{HALF_WIDTH{1'b0}}, up_next};
    end

    // Valid flag of the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload of the output register.
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            root_reg <= root_next;
            rem_reg  <= rem;
            up_reg   <= up_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_root       = root_reg;
    assign m_remainder  = rem_reg;
    assign m_rounded_up = up_reg;

endmodule

// ----- src/integer_square_root_rounded.sv -----
`timescale 1ns / 1ps

// Integer square root with optional rounding to nearest.
// A radicand word enters on the s_ channel (s_valid / s_ready) and one result
// word leaves on the m_ channel (m_valid / m_ready) for every radicand: the
// root, the floor remainder and a flag that marks a rounding step.
// cfg_wr_en with cfg_wr_data writes the rounding mode in the same cycle:
// 0 gives the floor root, 1 rounds to the nearest integer. Write it only
// while no word is in flight.
// A radicand passes through the chain of cells, one per root bit, each cell
// doing one trial subtraction, and then through the output register.
// Throughput is one word per cycle while the receiver keeps up; every cell and
// the output register holds one word, so up to HALF_WIDTH + 1 are in flight.
// When the receiver stalls, the held word stays on the m_ ports unchanged;
// cells behind it keep filling until the chain is full, and only then does
// s_ready fall. Reset empties the chain and sets floor mode.
module integer_square_root_rounded #(
    parameter int RADICAND_WIDTH = isrr_pkg::DEFAULT_RADICAND_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [0:0]                            cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [RADICAND_WIDTH-1:0]             s_radicand,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [(RADICAND_WIDTH+1)/2:0]         m_root,
    output logic [(RADICAND_WIDTH+1)/2:0]         m_remainder,
    output logic                                  m_rounded_up
);

    localparam int HALF_WIDTH = (RADICAND_WIDTH + 1) / 2;
    localparam int WALK_WIDTH = 2 * HALF_WIDTH;

    isrr_pkg::round_mode_t round_mode_reg;

    logic                  valid_chain [0:HALF_WIDTH];
    logic                  ready_chain [0:HALF_WIDTH];
    logic [WALK_WIDTH-1:0] part_chain  [0:HALF_WIDTH];
    logic [WALK_WIDTH-1:0] acc_chain   [0:HALF_WIDTH];
    logic [HALF_WIDTH-1:0] cell_valid;

    // Rounding mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_mode_reg <= isrr_pkg::ROUND_FLOOR;
        end else if (cfg_wr_en) begin
            round_mode_reg <= isrr_pkg::round_mode_t'(cfg_wr_data);
        end
    end

    // The walk starts with the whole radicand as remainder and a zero root.
    assign valid_chain[0] = s_valid;
    assign s_ready        = ready_chain[0];
    assign part_chain[0]  = WALK_WIDTH'(s_radicand);
    assign acc_chain[0]   = '0;

    // Chain of cells, one per root bit.
    for (genvar g = 0; g < HALF_WIDTH; g++) begin : g_cell
        isrr_cell #(
            .WALK_WIDTH (WALK_WIDTH),
            .STAGE      (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_chain[g]),
            .in_ready  (ready_chain[g]),
            .in_part   (part_chain[g]),
            .in_acc    (acc_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_ready (ready_chain[g+1]),
            .out_part  (part_chain[g+1]),
            .out_acc   (acc_chain[g+1])
        );
        assign cell_valid[g] = valid_chain[g+1];
    end

    // Rounding and output register.
    isrr_round #(
        .HALF_WIDTH (HALF_WIDTH)
    ) u_round (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .round_mode   (round_mode_reg),
        .in_valid     (valid_chain[HALF_WIDTH]),
        .in_ready     (ready_chain[HALF_WIDTH]),
        .in_part      (part_chain[HALF_WIDTH]),
        .in_acc       (acc_chain[HALF_WIDTH]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_root       (m_root),
        .m_remainder  (m_remainder),
        .m_rounded_up (m_rounded_up)
    );

    // A rounding step is only ever taken in nearest mode.
    a_round_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rounded_up |-> round_mode_reg == isrr_pkg::ROUND_NEAREST)
        else $error("rounded_up set in floor mode");

    // A floor result never leaves a remainder above twice the root.
    a_floor_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rounded_up |-> {1'b0, m_remainder} <= {m_root, 1'b0})
        else $error("floor remainder out of range");

    // A rounded result comes from a remainder of at least the rounded root.
    a_round_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rounded_up |-> m_remainder >= m_root)
        else $error("rounding step without remainder above floor root");

    // The input is held off only when every stage is full and the output stalls.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&cell_valid) && m_valid && !m_ready)
        else $error("input stalled with room in the chain");

endmodule

// ----- tb/isrr_result_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the square root unit, works out the expected
// root, floor remainder and rounding flag for every accepted radicand word,
// and compares each result word with the oldest one still outstanding.
module isrr_result_checker #(
    parameter int RADICAND_WIDTH = isrr_pkg::DEFAULT_RADICAND_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [RADICAND_WIDTH-1:0]     s_radicand,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [(RADICAND_WIDTH+1)/2:0] m_root,
    input  logic [(RADICAND_WIDTH+1)/2:0] m_remainder,
    input  logic                          m_rounded_up,
    output int                            words_pending,
    output int                            mismatches
);

    localparam int HALF_W = (RADICAND_WIDTH + 1) / 2;
    localparam int OUT_W  = HALF_W + 1;

    typedef struct packed {
        logic [OUT_W-1:0] root;
        logic [OUT_W-1:0] remainder;
        logic             rounded_up;
    } sqrt_word_t;

    sqrt_word_t            expected_words[$];
    isrr_pkg::round_mode_t round_setting;
    int                    fail_count;

    assign mismatches = fail_count;

    // Restoring binary square root: one trial subtraction per root bit, with
    // the test bit walking down two places at a time.
    function automatic sqrt_word_t predict_sqrt(input logic [RADICAND_WIDTH-1:0] radicand,
                                                input isrr_pkg::round_mode_t mode);
        logic [63:0] part;
        logic [63:0] acc;
        logic [63:0] probe;
        logic [63:0] trial;
        sqrt_word_t  w;
        part  = 64'(radicand);
        acc   = '0;
        probe = 64'd1 << (2 * HALF_W - 2);
        for (int i = 0; i < HALF_W; i++) begin
            trial = acc + probe;
            if (part >= trial) begin
                part = part - trial;
                acc  = trial + probe;
            end
            acc   = acc >> 1;
            probe = probe >> 2;
        end
        w.root       = OUT_W'(acc);
        w.remainder  = OUT_W'(part);
        w.rounded_up = 1'b0;
        // Nearest mode steps up when the remainder passes the floor root.
        if (mode == isrr_pkg::ROUND_NEAREST && part > acc) begin
            w.root       = OUT_W'(acc + 64'd1);
            w.rounded_up = 1'b1;
        end
        return w;
    endfunction

    initial begin
        fail_count    = 0;
        round_setting = isrr_pkg::ROUND_FLOOR;
    end

    // Queue a prediction per accepted radicand and check each result word.
    always @(posedge aclk) begin
        sqrt_word_t want;
        if (!aresetn) begin
            round_setting = isrr_pkg::ROUND_FLOOR;
            expected_words.delete();
            words_pending <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_words.push_back(predict_sqrt(s_radicand, round_setting));
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none outstanding: root %0d, remainder %0d",
                             $time, m_root, m_remainder);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_root !== want.root) begin
                        $display("%0t: m_root expected %0d, got %0d", $time, want.root, m_root);
                        fail_count++;
                    end
                    if (m_remainder !== want.remainder) begin
                        $display("%0t: m_remainder expected %0d, got %0d",
                                 $time, want.remainder, m_remainder);
                        fail_count++;
                    end
                    if (m_rounded_up !== want.rounded_up) begin
                        $display("%0t: m_rounded_up expected %0b, got %0b",
                                 $time, want.rounded_up, m_rounded_up);
                        fail_count++;
                    end
                end
            end
            // The mode must only change while nothing is in flight; the checker does not enforce it.
            if (cfg_wr_en) begin
                round_setting = isrr_pkg::round_mode_t'(cfg_wr_data);
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

// ----- tb/tb_integer_square_root_rounded.sv -----
`timescale 1ns / 1ps

module tb_integer_square_root_rounded;

    localparam int RW             = isrr_pkg::DEFAULT_RADICAND_WIDTH;
    localparam int OUT_W          = (RW + 1) / 2 + 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 130;
    localparam int HOLD_CYCLES    = 90;
    localparam int HOLD_WORDS     = 45;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [0:0]       cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    logic [RW-1:0]    s_radicand;
    logic             m_valid;
    logic             m_ready;
    logic [OUT_W-1:0] m_root;
    logic [OUT_W-1:0] m_remainder;
    logic             m_rounded_up;
    int               words_pending;
    int               mismatches;
    bit               hold_req;
    int               quiet_cycles;

    // Corner radicands: zero, one, squares, both sides of a half step, the
    // top square, values that round up to 65536 or just miss it, and alternating bits.
    localparam logic [31:0] CORNER_RADICANDS [12] = '{
        32'd0, 32'd1, 32'd4, 32'd6, 32'd7, 32'h4000_0000,
        32'hFFFE_0001, 32'hFFFF_0000, 32'hFFFF_0001, 32'hFFFF_FFFF,
        32'hAAAA_AAAA, 32'h5555_5555
    };

    localparam isrr_pkg::round_mode_t PHASE_MODES [5] = '{
        isrr_pkg::ROUND_FLOOR, isrr_pkg::ROUND_NEAREST, isrr_pkg::ROUND_NEAREST,
        isrr_pkg::ROUND_FLOOR, isrr_pkg::ROUND_NEAREST
    };

    integer_square_root_rounded #(
        .RADICAND_WIDTH(RW)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_radicand   (s_radicand),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_root       (m_root),
        .m_remainder  (m_remainder),
        .m_rounded_up (m_rounded_up)
    );

    isrr_result_checker #(
        .RADICAND_WIDTH(RW)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_radicand    (s_radicand),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_root        (m_root),
        .m_remainder   (m_remainder),
        .m_rounded_up  (m_rounded_up),
        .words_pending (words_pending),
        .mismatches    (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Radicands that favour squares and the points either side of a half
    // step, with plenty of fully random words so that every bit toggles.
    function automatic logic [31:0] pick_radicand();
        logic [31:0] n;
        logic [31:0] sq;
        logic [31:0] value;
        n  = $urandom_range(0, 65535);
        sq = n * n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                value = $urandom();
            end
            4, 5: begin
                case ($urandom_range(0, 4))
                    0: value = sq;
                    1: value = sq + n;
                    2: value = sq + n + 1;
                    3: value = sq + 2 * n;
                    default: value = sq - 1;
                endcase
            end
            6: begin
                value = $urandom_range(0, 300);
            end
            7: begin
                value = 32'hFFFF_0000 | $urandom_range(0, 65535);
            end
            8: begin
                value = 32'h1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) begin
                    value = ~value;
                end
            end
            default: begin
                value = $urandom() >> $urandom_range(0, 31);
            end
        endcase
        return value;
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [31:0] value);
        s_valid    <= 1'b1;
        s_radicand <= RW'(value);
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every result word has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
    endtask

    task automatic write_round_mode(input isrr_pkg::round_mode_t mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Stimulus: corner words in both modes, then random phases in bursts.
    initial begin
        int sent;
        int burst;
        int gap;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= isrr_pkg::ROUND_FLOOR;
        s_valid     <= 1'b0;
        s_radicand  <= '0;
        hold_req    <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Floor mode straight from reset, then nearest mode.
        foreach (CORNER_RADICANDS[i]) begin
            send_word(CORNER_RADICANDS[i]);
        end
        wait_idle();
        write_round_mode(isrr_pkg::ROUND_NEAREST);
        foreach (CORNER_RADICANDS[i]) begin
            send_word(CORNER_RADICANDS[i]);
        end

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            write_round_mode(PHASE_MODES[ph]);
            sent = 0;
            // Once, the receiver holds off while words keep coming, so the
            // chain fills and the input stalls.
            if (ph == 2) begin
                hold_req <= 1'b1;
                for (int k = 0; k < HOLD_WORDS; k++) begin
                    send_word(pick_radicand());
                end
                sent = HOLD_WORDS;
            end
            while (sent < PHASE_WORDS) begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && sent < PHASE_WORDS; k++) begin
                    send_word(pick_radicand());
                    sent++;
                end
                if (sent < PHASE_WORDS) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        s_valid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                end
            end
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Receiver: runs of always ready, random stalls and a fixed pattern,
    // plus one long hold-off when asked for.
    initial begin
        int run_left;
        int style;
        int hold_left;
        bit hold_done;
        run_left  = 0;
        style     = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    style    = $urandom_range(0, 3);
                    run_left = $urandom_range(5, 60);
                end
                run_left--;
                case (style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(0, 1);
                    2: m_ready <= (run_left % 3 == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: give up when no word moves on either channel for too long.
    initial quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- filelist.f -----
src/isrr_pkg.sv
src/isrr_cell.sv
src/isrr_round.sv
src/integer_square_root_rounded.sv
tb/isrr_result_checker.sv
tb/tb_integer_square_root_rounded.sv
